[design/trsm_pkg.sv]
// shared types, codes and constants of the token ring station mac
package trsm_pkg;

    // default configuration of storage
    localparam int DEF_QUEUE_DEPTH = 16;

    // address compare width
    localparam int ADDR_BITS = 8;
    localparam logic [7:0] ADDR_MASK = (ADDR_BITS >= 8) ? 8'hFF : 8'((1 << ADDR_BITS) - 1);

    // frame overheads in bits
    localparam logic [16:0] HEADER_BITS = 17'd168;
    localparam logic [15:0] TOKEN_BITS  = 16'd24;

    // register reset values
    localparam logic [7:0]  RST_STATION_ADDRESS = 8'd0;
    localparam logic [4:0]  RST_QUEUE_LIMIT     = 5'd16;
    localparam logic [23:0] RST_HOLDING_BUDGET  = 24'd160000;

    // configuration register indexes
    localparam logic [1:0] REG_STATION_ADDRESS = 2'd0;
    localparam logic [1:0] REG_QUEUE_LIMIT     = 2'd1;
    localparam logic [1:0] REG_HOLDING_BUDGET  = 2'd2;

    // command codes
    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_TOKEN  = 2'd1;
    localparam logic [1:0] CMD_FRAME  = 2'd2;
    localparam logic [1:0] CMD_START  = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_FRAME_SENT = 3'd0;
    localparam logic [2:0] KIND_TOKEN_SENT = 3'd1;
    localparam logic [2:0] KIND_FORWARDED  = 3'd2;
    localparam logic [2:0] KIND_DELIVERED  = 3'd3;
    localparam logic [2:0] KIND_STRIPPED   = 3'd4;
    localparam logic [2:0] KIND_ENQUEUED   = 3'd5;
    localparam logic [2:0] KIND_DROP_IDLE  = 3'd6;

    // input beat
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  dest_addr;
        logic [7:0]  src_addr;
        logic [15:0] length_bits;
    } item_t;

    // result beat
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_dest;
        logic [7:0]  out_source;
        logic [15:0] out_length_bits;
        logic [4:0]  queue_count;
        logic        last;
    } result_t;

    // classified operation handed from front to back
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  dst;
        logic [7:0]  src;
        logic [15:0] len;
        logic        dst_me;
        logic        src_me;
        logic        me_zero;
    } op_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [7:0]  station_address;
        logic [4:0]  queue_limit;
        logic [23:0] holding_budget_bits;
    } cfg_t;

endpackage

[design/trsm_front.sv]
// front end: configuration registers, command accept and classification
module trsm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  trsm_pkg::item_t    item,
    input  logic               opq_full,
    output logic               push,
    output trsm_pkg::op_t      push_op,
    output trsm_pkg::cfg_t     cfg
);
    import trsm_pkg::*;

    logic [7:0]  station_address_reg;
    logic [4:0]  queue_limit_reg;
    logic [23:0] holding_budget_reg;
    logic [7:0]  me;
    logic [7:0]  dst;
    logic [7:0]  src;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_address_reg <= RST_STATION_ADDRESS;
            queue_limit_reg     <= RST_QUEUE_LIMIT;
            holding_budget_reg  <= RST_HOLDING_BUDGET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STATION_ADDRESS: station_address_reg <= cfg_data[7:0];
                REG_QUEUE_LIMIT:     queue_limit_reg     <= cfg_data[4:0];
                REG_HOLDING_BUDGET:  holding_budget_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // masked addresses and comparisons
    assign me  = station_address_reg & ADDR_MASK;
    assign dst = item.dest_addr & ADDR_MASK;
    assign src = item.src_addr & ADDR_MASK;

    assign busy = opq_full;
    assign push = start && !opq_full;

    // classified operation
    always_comb
    begin
        push_op.cmd     = item.command;
        push_op.dst     = dst;
        push_op.src     = src;
        push_op.len     = item.length_bits;
        push_op.dst_me  = (dst == me);
        push_op.src_me  = (src == me);
        push_op.me_zero = (me == 8'd0);
    end

    assign cfg.station_address     = me;
    assign cfg.queue_limit         = queue_limit_reg;
    assign cfg.holding_budget_bits = holding_budget_reg;

endmodule

[design/trsm_opq.sv]
// two-entry operation queue between front and back
module trsm_opq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  trsm_pkg::op_t  push_op,
    input  logic           pop,
    output logic           full,
    output logic           valid,
    output trsm_pkg::op_t  head_op
);
    import trsm_pkg::*;

    op_t        entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign head_op = entry_reg[rptr_reg];

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_op;
        end
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

[design/trsm_ram.sv]
// generic single write, single read ram with registered read
module trsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[design/trsm_back.sv]
// back end: send queue, token holding and result generation
module trsm_back #(
    parameter int QUEUE_DEPTH = trsm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  trsm_pkg::cfg_t    cfg,
    input  logic              op_valid,
    input  trsm_pkg::op_t     op_head,
    output logic              pop,
    output logic              result_valid,
    output trsm_pkg::result_t result
);
    import trsm_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > 5) ? FILL_W : 5;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(QUEUE_DEPTH);

    // back end states
    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_FRAME_FWD = 2'd1;
    localparam logic [1:0] ST_TOK_READ = 2'd2;
    localparam logic [1:0] ST_TOK_EVAL = 2'd3;

    logic [1:0]        state_reg, state_next;
    op_t               op_reg, op_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [23:0]       used_reg, used_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic              wr_en;
    logic [23:0]       rd_data;
    logic [CMP_W-1:0]  fill_c;
    logic [CMP_W-1:0]  limit_c;
    logic [CMP_W-1:0]  lim;
    logic [4:0]        count_now;
    logic [4:0]        count_inc;
    logic [4:0]        count_dec;
    logic [16:0]       fbits;
    logic [24:0]       sum;
    logic [15:0]       fbits_sat;
    logic [15:0]       deliver_len;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  tail_inc;

    function automatic result_t make_result(input logic [2:0] kind, input logic [7:0] dst,
                                            input logic [7:0] src, input logic [15:0] len,
                                            input logic [4:0] count, input logic last);
        result_t r;
        r.kind            = kind;
        r.out_dest        = dst;
        r.out_source      = src;
        r.out_length_bits = len;
        r.queue_count     = count;
        r.last            = last;
        return r;
    endfunction

    // packet store, destination over length
    trsm_ram #(
        .WIDTH (24),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data ({op_head.dst, op_head.len}),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    // fill and limit arithmetic
    assign fill_c    = CMP_W'(fill_reg);
    assign limit_c   = CMP_W'(cfg.queue_limit);
    assign lim       = (limit_c > DEPTH_C) ? DEPTH_C : limit_c;
    assign count_now = fill_c[4:0];
    assign count_inc = count_now + 5'd1;
    assign count_dec = count_now - 5'd1;
    assign head_inc  = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc  = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);

    // frame size and budget check for the head packet
    assign fbits       = HEADER_BITS + {1'b0, rd_data[15:0]};
    assign sum         = {1'b0, used_reg} + {8'd0, fbits};
    assign fbits_sat   = fbits[16] ? 16'hFFFF : fbits[15:0];
    assign deliver_len = (op_head.len > HEADER_BITS[15:0]) ?
                         op_head.len - HEADER_BITS[15:0] : 16'd0;

    // control and result generation
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        fill_next         = fill_reg;
        used_next         = used_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        pop               = 1'b0;
        wr_en             = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    pop     = 1'b1;
                    op_next = op_head;
                    case (op_head.cmd)
                        CMD_PACKET:
                        begin
                            result_valid_next = 1'b1;
                            if (fill_c >= lim)
                            begin
                                result_next = make_result(KIND_DROP_IDLE, op_head.dst,
                                    cfg.station_address, op_head.len, count_now, 1'b1);
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                tail_next   = tail_inc;
                                fill_next   = fill_reg + FILL_W'(1);
                                result_next = make_result(KIND_ENQUEUED, op_head.dst,
                                    cfg.station_address, op_head.len, count_inc, 1'b1);
                            end
                        end
                        CMD_TOKEN:
                        begin
                            used_next  = 24'd0;
                            state_next = ST_TOK_READ;
                        end
                        CMD_FRAME:
                        begin
                            result_valid_next = 1'b1;
                            if (op_head.dst_me)
                            begin
                                result_next = make_result(KIND_DELIVERED, op_head.dst,
                                    op_head.src, deliver_len, count_now, 1'b0);
                                state_next  = ST_FRAME_FWD;
                            end
                            else
                            begin
                                result_next = make_result(
                                    op_head.src_me ? KIND_STRIPPED : KIND_FORWARDED,
                                    op_head.dst, op_head.src, op_head.len, count_now, 1'b1);
                            end
                        end
                        default:
                        begin
                            result_valid_next = 1'b1;
                            if (op_head.me_zero)
                            begin
                                result_next = make_result(KIND_TOKEN_SENT, 8'd0, 8'd0,
                                    TOKEN_BITS, count_now, 1'b1);
                            end
                            else
                            begin
                                result_next = make_result(KIND_DROP_IDLE, 8'd0, 8'd0,
                                    16'd0, count_now, 1'b1);
                            end
                        end
                    endcase
                end
            end
            ST_FRAME_FWD:
            begin
                result_valid_next = 1'b1;
                result_next = make_result(op_reg.src_me ? KIND_STRIPPED : KIND_FORWARDED,
                    op_reg.dst, op_reg.src, op_reg.len, count_now, 1'b1);
                state_next  = ST_IDLE;
            end
            ST_TOK_READ:
            begin
                // head entry read is in flight
                state_next = ST_TOK_EVAL;
            end
            ST_TOK_EVAL:
            begin
                result_valid_next = 1'b1;
                if ((fill_reg == '0) || (sum > {1'b0, cfg.holding_budget_bits}))
                begin
                    result_next = make_result(KIND_TOKEN_SENT, 8'd0, 8'd0,
                        TOKEN_BITS, count_now, 1'b1);
                    state_next  = ST_IDLE;
                end
                else
                begin
                    used_next   = sum[23:0];
                    head_next   = head_inc;
                    fill_next   = fill_reg - FILL_W'(1);
                    result_next = make_result(KIND_FRAME_SENT, rd_data[23:16],
                        cfg.station_address, fbits_sat, count_dec, 1'b0);
                    state_next  = ST_TOK_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            fill_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            fill_reg         <= fill_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        used_reg   <= used_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[design/token_ring_station_mac.sv]
// top level of one token ring station mac
//
//  channel   signals                                     direction  beat taken when
//  command   start, busy, item                           in         start && !busy
//  result    result_valid, result                        out        result_valid
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   in         cfg_valid && cfg_ready
//
// a command is written into a two-entry queue; the back end then handles a packet or
// start in its idle state, a frame in the idle state and, if delivered here, a forward
// state, and a token in the idle state, then a read and an evaluate state per frame
// sent and for the token release. each result shows in the cycle after its state.
// busy is high while the command queue is full; reset clears the send queue
// pointers and the command queue, the packet store itself is not cleared.
// results cannot be stalled, each is shown for exactly one cycle.
module token_ring_station_mac #(
    parameter int QUEUE_DEPTH = trsm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [23:0]       cfg_data,
    input  logic              start,
    output logic              busy,
    input  trsm_pkg::item_t   item,
    output logic              result_valid,
    output trsm_pkg::result_t result
);
    import trsm_pkg::*;

    logic push;
    op_t  push_op;
    logic opq_full;
    logic op_valid;
    op_t  op_head;
    logic pop;
    cfg_t cfg;

    // command accept and classification
    trsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .opq_full  (opq_full),
        .push      (push),
        .push_op   (push_op),
        .cfg       (cfg)
    );

    // decoupling queue
    trsm_opq u_opq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .full    (opq_full),
        .valid   (op_valid),
        .head_op (op_head)
    );

    // execution
    trsm_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .op_valid     (op_valid),
        .op_head      (op_head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[verif/tb.sv]
// testbench for the token ring station mac: directed table, then random phases against a predictor
`timescale 1ns / 1ps

module tb;
    import trsm_pkg::*;

    localparam int QDEPTH       = DEF_QUEUE_DEPTH;
    localparam int N_DIR        = 26;
    localparam int N_PHASES     = 5;
    localparam int PHASE_ITEMS  = 14;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    // kinds of rows in the directed table
    typedef enum bit [1:0] {
        ROW_REG,
        ROW_PREDICT,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [23:0] reg_val;
        item_t       cmd;
        result_t     want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        start;
    logic        busy;
    item_t       cmd_beat;
    logic        result_valid;
    result_t     res_beat;

    // station model: configuration and send queue
    logic [7:0]  st_addr   = RST_STATION_ADDRESS;
    logic [4:0]  st_limit  = RST_QUEUE_LIMIT;
    logic [23:0] st_budget = RST_HOLDING_BUDGET;
    logic [7:0]  q_dest [QDEPTH];
    logic [15:0] q_len  [QDEPTH];
    int unsigned q_head = 0;
    int unsigned q_fill = 0;

    result_t     step_results[$];
    result_t     pending_results[$];
    result_t     oldest;
    int          mismatches  = 0;
    int unsigned cycle_count = 0;

    dir_row_t    dir_tab [N_DIR];

    token_ring_station_mac DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .item         (cmd_beat),
        .result_valid (result_valid),
        .result       (res_beat)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic item_t mk_item(input logic [1:0] c, input logic [7:0] d,
                                      input logic [7:0] s, input logic [15:0] l);
        item_t it;
        it.command     = c;
        it.dest_addr   = d;
        it.src_addr    = s;
        it.length_bits = l;
        return it;
    endfunction

    function automatic result_t mk_res(input logic [2:0] k, input logic [7:0] d,
                                       input logic [7:0] s, input logic [15:0] l,
                                       input logic [4:0] qc);
        result_t r;
        r.kind            = k;
        r.out_dest        = d;
        r.out_source      = s;
        r.out_length_bits = l;
        r.queue_count     = qc;
        r.last            = 1'b1;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [23:0] val);
        dir_row_t row;
        row         = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic dir_row_t item_row(input item_t it);
        dir_row_t row;
        row      = '0;
        row.kind = ROW_PREDICT;
        row.cmd  = it;
        return row;
    endfunction

    function automatic dir_row_t typed_row(input item_t it, input result_t r);
        dir_row_t row;
        row      = '0;
        row.kind = ROW_TYPED;
        row.cmd  = it;
        row.want = r;
        return row;
    endfunction

    function automatic string fmt_res(input result_t r);
        return $sformatf("kind=%0d dest=%02h src=%02h len=%0d qcnt=%0d last=%0d",
                         r.kind, r.out_dest, r.out_source, r.out_length_bits,
                         r.queue_count, r.last);
    endfunction

    // append one result of the current beat, length saturating at 16 bits
    function automatic void add_result(input logic [2:0] k, input logic [7:0] d,
                                       input logic [7:0] s, input int unsigned l);
        result_t r;
        r.kind            = k;
        r.out_dest        = d;
        r.out_source      = s;
        r.out_length_bits = (l > 32'hFFFF) ? 16'hFFFF : l[15:0];
        r.queue_count     = q_fill[4:0];
        r.last            = 1'b0;
        step_results.push_back(r);
    endfunction

    // advance the station model by one command beat
    function automatic void ring_step(input item_t it);
        logic [7:0]  dst;
        logic [7:0]  src;
        logic [7:0]  me;
        logic [15:0] len;
        int unsigned lim;
        int unsigned slot;
        int unsigned used;
        int unsigned fbits;
        int unsigned h;
        dst = it.dest_addr & ADDR_MASK;
        src = it.src_addr & ADDR_MASK;
        me  = st_addr & ADDR_MASK;
        len = it.length_bits;
        step_results.delete();
        case (it.command)
            CMD_PACKET:
            begin
                lim = (st_limit > QDEPTH) ? QDEPTH : st_limit;
                if (q_fill >= lim)
                begin
                    add_result(KIND_DROP_IDLE, dst, me, len);
                end
                else
                begin
                    slot         = (q_head + q_fill) % QDEPTH;
                    q_dest[slot] = dst;
                    q_len[slot]  = len;
                    q_fill++;
                    add_result(KIND_ENQUEUED, dst, me, len);
                end
            end
            CMD_TOKEN:
            begin
                used = 0;
                // send from the head while the next frame still fits the budget
                while (q_fill > 0)
                begin
                    h     = q_head;
                    fbits = HEADER_BITS + q_len[h];
                    if (used + fbits > st_budget)
                        break;
                    used   = used + fbits;
                    q_head = (h + 1) % QDEPTH;
                    q_fill--;
                    add_result(KIND_FRAME_SENT, q_dest[h], me, fbits);
                end
                add_result(KIND_TOKEN_SENT, 8'd0, 8'd0, TOKEN_BITS);
            end
            CMD_FRAME:
            begin
                if (dst == me)
                    add_result(KIND_DELIVERED, dst, src,
                               (len > HEADER_BITS) ? len - HEADER_BITS : 0);
                if (src == me)
                    add_result(KIND_STRIPPED, dst, src, len);
                else
                    add_result(KIND_FORWARDED, dst, src, len);
            end
            default:
            begin
                if (me == 8'd0)
                    add_result(KIND_TOKEN_SENT, 8'd0, 8'd0, TOKEN_BITS);
                else
                    add_result(KIND_DROP_IDLE, 8'd0, 8'd0, 0);
            end
        endcase
        step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    // random command beat biased toward this station's address and short packets
    function automatic item_t rand_item(input logic [1:0] c);
        item_t it;
        int    r;
        it.command     = c;
        it.dest_addr   = 8'($urandom);
        it.src_addr    = 8'($urandom);
        it.length_bits = 16'($urandom);
        r = $urandom_range(0, 99);
        if (c == CMD_FRAME)
        begin
            if ($urandom_range(0, 99) < 35)
                it.dest_addr = st_addr;
            if ($urandom_range(0, 99) < 35)
                it.src_addr = st_addr;
            if (r < 60)
                it.length_bits = 16'($urandom_range(0, 2000));
        end
        else if (c == CMD_PACKET)
        begin
            if (r < 70)
                it.length_bits = 16'($urandom_range(0, 600));
            else if (r >= 92)
                it.length_bits = 16'd0;
            else if (r >= 85)
                it.length_bits = 16'hFFFF;
        end
        return it;
    endfunction

    // one command beat; start stays high afterward until the caller lowers it
    task automatic drive_item(input item_t it, input bit typed, input result_t want);
        @(negedge clk);
        start    <= 1'b1;
        cmd_beat <= it;
        do
            @(posedge clk);
        while (busy);
        ring_step(it);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
    endtask

    // register write beat, issued only once every pending result has arrived
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_STATION_ADDRESS: st_addr   = val[7:0];
            REG_QUEUE_LIMIT:     st_limit  = val[4:0];
            REG_HOLDING_BUDGET:  st_budget = val;
            default:             ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // sender idles each cycle with the given chance in a hundred
    task automatic sender_gap(input int pct);
        bit lowered;
        lowered = 1'b0;
        while ($urandom_range(0, 99) < pct)
        begin
            if (!lowered)
            begin
                @(negedge clk);
                start   <= 1'b0;
                lowered = 1'b1;
            end
            @(posedge clk);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %s",
                         $time, fmt_res(res_beat));
                mismatches++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (res_beat !== oldest)
                begin
                    $display("%0t result mismatch: expected %s, actual %s",
                             $time, fmt_res(oldest), fmt_res(res_beat));
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL token_ring_station_mac");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int phase;
        int n;
        int burst;
        int pct;
        int r;
        rst_n     = 1'b0;
        start     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cmd_beat  = '0;

        // directed table: extremes, every command and the special cases
        dir_tab = '{
            typed_row(mk_item(CMD_START, 8'h00, 8'h00, 16'h0000),
                      mk_res(KIND_TOKEN_SENT, 8'h00, 8'h00, TOKEN_BITS, 5'd0)),
            typed_row(mk_item(CMD_TOKEN, 8'hFF, 8'hFF, 16'hFFFF),
                      mk_res(KIND_TOKEN_SENT, 8'h00, 8'h00, TOKEN_BITS, 5'd0)),
            item_row(mk_item(CMD_FRAME, 8'h00, 8'h00, 16'h0000)),
            typed_row(mk_item(CMD_FRAME, 8'hFF, 8'hFF, 16'hFFFF),
                      mk_res(KIND_FORWARDED, 8'hFF, 8'hFF, 16'hFFFF, 5'd0)),
            typed_row(mk_item(CMD_PACKET, 8'hFF, 8'h5A, 16'hFFFF),
                      mk_res(KIND_ENQUEUED, 8'hFF, 8'h00, 16'hFFFF, 5'd1)),
            item_row(mk_item(CMD_PACKET, 8'h00, 8'h00, 16'h0000)),
            item_row(mk_item(CMD_TOKEN, 8'h00, 8'h00, 16'h0000)),
            item_row(mk_item(CMD_FRAME, 8'h00, 8'h55, 16'd169)),
            item_row(mk_item(CMD_FRAME, 8'hAA, 8'h00, 16'd100)),
            reg_row(REG_STATION_ADDRESS, 24'h0000A5),
            typed_row(mk_item(CMD_START, 8'h12, 8'h34, 16'h5678),
                      mk_res(KIND_DROP_IDLE, 8'h00, 8'h00, 16'h0000, 5'd0)),
            item_row(mk_item(CMD_FRAME, 8'hA5, 8'hA5, 16'd168)),
            reg_row(REG_QUEUE_LIMIT, 24'd0),
            typed_row(mk_item(CMD_PACKET, 8'h03, 8'h00, 16'd7),
                      mk_res(KIND_DROP_IDLE, 8'h03, 8'hA5, 16'd7, 5'd0)),
            reg_row(REG_QUEUE_LIMIT, 24'd2),
            reg_row(REG_HOLDING_BUDGET, 24'd178),
            item_row(mk_item(CMD_PACKET, 8'h01, 8'h00, 16'd10)),
            item_row(mk_item(CMD_PACKET, 8'h02, 8'h00, 16'd11)),
            item_row(mk_item(CMD_PACKET, 8'h03, 8'h00, 16'd5)),
            item_row(mk_item(CMD_TOKEN, 8'h00, 8'h00, 16'h0000)),
            reg_row(REG_HOLDING_BUDGET, 24'd0),
            item_row(mk_item(CMD_TOKEN, 8'h00, 8'h00, 16'h0000)),
            reg_row(REG_QUEUE_LIMIT, 24'd20),
            reg_row(REG_HOLDING_BUDGET, 24'hFFFFFF),
            item_row(mk_item(CMD_TOKEN, 8'h00, 8'h00, 16'h0000)),
            item_row(mk_item(CMD_START, 8'h00, 8'h00, 16'h0000))
        };

        // reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_REG)
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            else
                drive_item(dir_tab[i].cmd, dir_tab[i].kind == ROW_TYPED, dir_tab[i].want);
        end

        // random phases, each with its own settings and idling
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_STATION_ADDRESS, 24'd0);
                    write_reg(REG_QUEUE_LIMIT, 24'd16);
                    write_reg(REG_HOLDING_BUDGET, 24'd160000);
                    pct = 0;
                end
                1:
                begin
                    write_reg(REG_STATION_ADDRESS, 24'hFF);
                    write_reg(REG_QUEUE_LIMIT, 24'd16);
                    write_reg(REG_HOLDING_BUDGET, 24'hFFFFFF);
                    pct = 76;
                end
                2:
                begin
                    write_reg(REG_STATION_ADDRESS, 24'($urandom_range(0, 255)));
                    write_reg(REG_QUEUE_LIMIT, 24'($urandom_range(1, 16)));
                    write_reg(REG_HOLDING_BUDGET, 24'($urandom_range(168, 4000)));
                    pct = 7;
                end
                3:
                begin
                    write_reg(REG_STATION_ADDRESS, 24'd0);
                    write_reg(REG_QUEUE_LIMIT, 24'd8);
                    write_reg(REG_HOLDING_BUDGET, 24'($urandom_range(0, 800)));
                    pct = 76;
                end
                default:
                begin
                    write_reg(REG_STATION_ADDRESS, 24'($urandom_range(0, 255)));
                    write_reg(REG_QUEUE_LIMIT, 24'($urandom_range(0, 16)));
                    write_reg(REG_HOLDING_BUDGET, 24'($urandom));
                    pct = 0;
                end
            endcase

            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 30)
                begin
                    // burst of packets then the token that drains them
                    burst = $urandom_range(1, 17);
                    repeat (burst)
                    begin
                        drive_item(rand_item(CMD_PACKET), 1'b0, '0);
                        sender_gap(pct);
                        n++;
                    end
                    drive_item(rand_item(CMD_TOKEN), 1'b0, '0);
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        drive_item(rand_item(CMD_PACKET), 1'b0, '0);
                    else if (r < 65)
                        drive_item(rand_item(CMD_TOKEN), 1'b0, '0);
                    else if (r < 92)
                        drive_item(rand_item(CMD_FRAME), 1'b0, '0);
                    else
                        drive_item(rand_item(CMD_START), 1'b0, '0);
                end
                sender_gap(pct);
                n++;
            end
        end

        // drain
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS token_ring_station_mac");
        else
            $display("FAIL token_ring_station_mac");
        $finish;
    end

endmodule

[sim.f]
design/trsm_pkg.sv
design/trsm_front.sv
design/trsm_opq.sv
design/trsm_ram.sv
design/trsm_back.sv
design/token_ring_station_mac.sv
verif/tb.sv
